FILE: sv/pbfs_pkg.sv
// Shared types and constants for the packed bit-field store.
package pbfs_pkg;

    localparam int STORE_BYTES_DEF = 256;

    typedef enum logic [1:0] {
        MODE_RD_FIELD = 2'd0,
        MODE_WR_FIELD = 2'd1,
        MODE_RD_WORD  = 2'd2,
        MODE_WR_WORD  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_RESP
    } state_t;

    typedef struct packed {
        mode_t       mode;
        logic [10:0] start_bit;
        logic [10:0] end_bit;
        logic [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        range_error;
    } rsp_t;

endpackage

FILE: sv/pbfs_ram.sv
// Byte-wide simple dual-port RAM, one write port, one registered read port.
module pbfs_ram #(
    parameter int DEPTH  = pbfs_pkg::STORE_BYTES_DEF,
    parameter int ADDR_W = $clog2(pbfs_pkg::STORE_BYTES_DEF)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/packed_bitfield_store_unit.sv
// Top level of the packed bit-field store: request decode, byte sequencer, RMW datapath.
//
//   channel   signals                 direction   handshake
//   request   start, busy, req        in          beat taken when start & !busy
//   result    done, rsp               out         one-cycle strobe, no back-pressure
//
// An item touches n bytes (1 or 2 for a field, 4 or 5 for a 32-bit value): one RAM read per
// byte through the single read port, write-back of each byte in the following cycle. A new
// request is taken only after the result of the last one has been strobed.
// A bad range strobes its result in the cycle after accept and leaves the store
// untouched.
// After reset a clearing pass writes zero to every byte, with busy high throughout.
// Results cannot be stalled.
module packed_bitfield_store_unit #(
    parameter int STORE_BYTES = pbfs_pkg::STORE_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  pbfs_pkg::req_t req,
    output logic           done,
    output pbfs_pkg::rsp_t rsp
);

    localparam int          AW         = $clog2(STORE_BYTES);
    localparam logic [15:0] STORE_BITS = 16'(STORE_BYTES * 8);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

    pbfs_pkg::state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [2:0]    k_reg, k_next;
    logic [AW-1:0] base_reg, base_next;
    logic [2:0]    nbytes_reg, nbytes_next;
    logic [2:0]    sh_reg, sh_next;
    logic [31:0]   mask_reg, mask_next;
    logic [39:0]   wdata_reg, wdata_next;
    logic [39:0]   wmask_reg, wmask_next;
    logic [39:0]   window_reg, window_next;
    logic          err_reg, err_next;
    logic          wr_reg, wr_next;
    logic          rd_reg, rd_next;

    logic          accept;
    logic          is_field;
    logic          req_err;
    logic [10:0]   wdiff;
    logic [3:0]    fwidth;
    logic [7:0]    mask8;
    logic [31:0]   req_mask;
    logic [2:0]    req_nbytes;
    logic [2:0]    j;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [7:0]    wm;
    logic [7:0]    wd;
    logic [31:0]   rd_result;

    pbfs_ram #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // request decode
    always_comb
    begin
        accept   = start && (state_reg == pbfs_pkg::S_IDLE);
        is_field = (req.mode == pbfs_pkg::MODE_RD_FIELD) || (req.mode == pbfs_pkg::MODE_WR_FIELD);
        wdiff    = req.end_bit - req.start_bit;
        fwidth   = {1'b0, wdiff[2:0]} + 4'd1;
        mask8    = 8'((9'd1 << fwidth) - 9'd1);
        if (is_field)
        begin
            req_err = (req.end_bit < req.start_bit) || (wdiff > 11'd7)
                   || ({5'b0, req.end_bit} >= STORE_BITS);
            req_mask   = {24'b0, mask8};
            req_nbytes = (req.end_bit[10:3] != req.start_bit[10:3]) ? 3'd2 : 3'd1;
        end
        else
        begin
            req_err    = ({5'b0, req.start_bit} + 16'd31) >= STORE_BITS;
            req_mask   = '1;
            req_nbytes = (req.start_bit[2:0] == 3'd0) ? 3'd4 : 3'd5;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbfs_pkg::S_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = pbfs_pkg::S_IDLE;
                end
            end
            pbfs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = req_err ? pbfs_pkg::S_RESP : pbfs_pkg::S_ACCESS;
                end
            end
            pbfs_pkg::S_ACCESS:
            begin
                if (k_reg == nbytes_reg)
                begin
                    state_next = pbfs_pkg::S_RESP;
                end
            end
            pbfs_pkg::S_RESP:
            begin
                state_next = pbfs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pbfs_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and RAM control
    always_comb
    begin
        j         = k_reg - 3'd1;
        wm        = wmask_reg[8*j +: 8];
        wd        = wdata_reg[8*j +: 8];
        rd_result = 32'(window_reg >> sh_reg) & mask_reg;
        busy      = (state_reg != pbfs_pkg::S_IDLE);
        done      = 1'b0;
        rsp       = '0;
        ram_we    = 1'b0;
        ram_waddr = base_reg + AW'(j);
        ram_wdata = (ram_rdata & ~wm) | (wd & wm);
        ram_raddr = base_reg + AW'(k_reg);
        unique case (state_reg)
            pbfs_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            pbfs_pkg::S_IDLE:
            begin
                ram_we = 1'b0;
            end
            pbfs_pkg::S_ACCESS:
            begin
                ram_we = wr_reg && (k_reg != 3'd0);
            end
            pbfs_pkg::S_RESP:
            begin
                done            = 1'b1;
                rsp.range_error = err_reg;
                rsp.read_value  = (rd_reg && !err_reg) ? rd_result : '0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        clr_next    = clr_reg;
        k_next      = k_reg;
        base_next   = base_reg;
        nbytes_next = nbytes_reg;
        sh_next     = sh_reg;
        mask_next   = mask_reg;
        wdata_next  = wdata_reg;
        wmask_next  = wmask_reg;
        window_next = window_reg;
        err_next    = err_reg;
        wr_next     = wr_reg;
        rd_next     = rd_reg;
        if (state_reg == pbfs_pkg::S_CLEAR)
        begin
            clr_next = clr_reg + AW'(1);
        end
        if (accept)
        begin
            k_next      = '0;
            base_next   = AW'(req.start_bit[10:3]);
            nbytes_next = req_nbytes;
            sh_next     = req.start_bit[2:0];
            mask_next   = req_mask;
            wdata_next  = 40'(req.write_value & req_mask) << req.start_bit[2:0];
            wmask_next  = 40'(req_mask) << req.start_bit[2:0];
            window_next = '0;
            err_next    = req_err;
            wr_next     = (req.mode == pbfs_pkg::MODE_WR_FIELD)
                       || (req.mode == pbfs_pkg::MODE_WR_WORD);
            rd_next     = (req.mode == pbfs_pkg::MODE_RD_FIELD)
                       || (req.mode == pbfs_pkg::MODE_RD_WORD);
        end
        if (state_reg == pbfs_pkg::S_ACCESS)
        begin
            k_next = k_reg + 3'd1;
            if (k_reg != 3'd0)
            begin
                window_next[8*j +: 8] = ram_rdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbfs_pkg::S_CLEAR;
            clr_reg   <= '0;
            k_reg     <= '0;
            err_reg   <= 1'b0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            k_reg     <= k_next;
            err_reg   <= err_next;
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        nbytes_reg <= nbytes_next;
        sh_reg     <= sh_next;
        mask_reg   <= mask_next;
        wdata_reg  <= wdata_next;
        wmask_reg  <= wmask_next;
        window_reg <= window_next;
    end

endmodule
